[rtl/mcipi_pkg.sv]
`timescale 1ns / 1ps
package mcipi_pkg;

	localparam int CH_W       = 2;
	localparam int SPEED_W    = 16;
	localparam int ERR_W      = SPEED_W + 1;
	localparam int DERR_W     = ERR_W + 1;
	localparam int GAIN_W     = 22;
	localparam int DZ_W       = 15;
	localparam int LIM_W      = 15;
	localparam int LEAK_W     = 9;
	localparam int ACC_W      = 32;
	localparam int ACC_FRAC   = 16;
	localparam int LEAK_FRAC  = 8;
	localparam int PROD_SHIFT = 4;
	localparam int PP_W       = GAIN_W + 1 + DERR_W;
	localparam int PI_W       = GAIN_W + 1 + ERR_W;
	localparam int PL_W       = ACC_W + LEAK_W + 1;
	localparam int SUM_W      = 38;
	localparam int HI_W       = SUM_W - ACC_FRAC;
	localparam int DRV_W      = 16;
	localparam int CFG_W      = 22;
	localparam int CFG_IDX_W  = 3;

	localparam logic [CFG_IDX_W-1:0] REG_KP   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KI   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DZ   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LIM  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LEAK = 3'd4;

	localparam logic [GAIN_W-1:0] KP_RESET   = 22'd1737216;
	localparam logic [GAIN_W-1:0] KI_RESET   = 22'd45824;
	localparam logic [DZ_W-1:0]   DZ_RESET   = 15'd82;
	localparam logic [LIM_W-1:0]  LIM_RESET  = 15'd16700;
	localparam logic [LEAK_W-1:0] LEAK_RESET = 9'd205;

	typedef struct packed {
		logic [CH_W-1:0]           motor_index;
		logic signed [SPEED_W-1:0] measured_speed;
		logic signed [SPEED_W-1:0] target_speed;
	} sample_t;

	typedef struct packed {
		logic [CH_W-1:0]         channel;
		logic signed [DRV_W-1:0] pwm_drive;
	} drive_t;

	typedef struct packed {
		logic signed [ACC_W-1:0] acc;
		logic signed [ERR_W-1:0] prev_err;
	} chan_state_t;

	typedef struct packed {
		logic [GAIN_W-1:0] kp;
		logic [GAIN_W-1:0] ki;
		logic [DZ_W-1:0]   dz;
		logic [LIM_W-1:0]  lim;
		logic [LEAK_W-1:0] leak;
	} cfg_t;

	typedef struct packed {
		logic ld1;
		logic ld2;
		logic ld3;
	} pipe_en_t;

	typedef struct packed {
		logic [CH_W-1:0]         ch;
		logic                    rng;
		chan_state_t             st;
		logic signed [DRV_W-1:0] drive;
	} result_t;

endpackage

[rtl/mcipi_state_mem.sv]
`timescale 1ns / 1ps
module mcipi_state_mem #(
	parameter int NUM_CHANNELS = 4,
	parameter int AW = 2
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   rd_en,
	input  logic [AW-1:0]          rd_addr,
	output mcipi_pkg::chan_state_t rd_data,
	input  logic                   wr_en,
	input  logic [AW-1:0]          wr_addr,
	input  mcipi_pkg::chan_state_t wr_data
);
	import mcipi_pkg::*;

	chan_state_t mem [NUM_CHANNELS];
	chan_state_t rd_raw_q;
	logic        rd_vld_q;
	logic [NUM_CHANNELS-1:0] written_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_raw_q <= mem[rd_addr];
		end
	end

	// an entry never written since reset reads as zero state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
			rd_vld_q  <= 1'b0;
		end else begin
			if (wr_en) begin
				written_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= written_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_raw_q : '0;

endmodule

[rtl/mcipi_datapath.sv]
`timescale 1ns / 1ps
module mcipi_datapath (
	input  logic                              clk,
	input  mcipi_pkg::pipe_en_t               en,
	input  mcipi_pkg::sample_t                smp,
	input  logic                              smp_rng,
	input  mcipi_pkg::chan_state_t            rd_st,
	input  mcipi_pkg::cfg_t                   cfg,
	output logic [2:0][mcipi_pkg::CH_W-1:0]   stage_ch,
	output mcipi_pkg::result_t                res
);
	import mcipi_pkg::*;

	localparam logic signed [PL_W-1:0] LEAK_RND = PL_W'((1 << LEAK_FRAC) - 1);

	// stage 1: error, state read data arrives
	logic [CH_W-1:0]          ch_s1;
	logic                     rng_s1;
	logic                     tz_s1;
	logic signed [ERR_W-1:0]  err_s1;
	logic signed [ERR_W-1:0]  err_in;
	logic signed [DERR_W-1:0] derr;
	logic [ERR_W-1:0]         mag;
	logic                     dz_hit;
	logic signed [PP_W-1:0]   prod_p;
	logic signed [PI_W-1:0]   prod_i;
	logic signed [PL_W-1:0]   prod_l;

	// stage 2: products
	logic [CH_W-1:0]          ch_s2;
	logic                     rng_s2;
	logic                     dz_s2;
	logic                     leak_s2;
	logic signed [ERR_W-1:0]  err_s2;
	logic signed [ACC_W-1:0]  acc_s2;
	logic signed [PP_W-1:0]   prod_p_s2;
	logic signed [PI_W-1:0]   prod_i_s2;
	logic signed [PL_W-1:0]   prod_l_s2;
	logic signed [SUM_W-1:0]  p_term;
	logic signed [SUM_W-1:0]  i_term;
	logic signed [PL_W-1:0]   leak_rnd;
	logic signed [SUM_W-1:0]  base;
	logic signed [SUM_W-1:0]  sum;

	// stage 3: saturation
	logic [CH_W-1:0]          ch_s3;
	logic                     rng_s3;
	logic signed [ERR_W-1:0]  err_s3;
	logic signed [SUM_W-1:0]  sum_s3;
	logic signed [SUM_W-1:0]  lim_full;
	logic signed [SUM_W-1:0]  acc_new;
	logic                     rnd_up;
	logic signed [HI_W-1:0]   hi_trunc;
	logic signed [HI_W-1:0]   lim_d;
	logic signed [HI_W-1:0]   drv_sel;

	assign err_in = ERR_W'(smp.target_speed) - ERR_W'(smp.measured_speed);

	always_ff @(posedge clk) begin
		if (en.ld1) begin
			ch_s1  <= smp.motor_index;
			rng_s1 <= smp_rng;
			tz_s1  <= (smp.target_speed == '0);
			err_s1 <= err_in;
		end
	end

	always_comb begin
		derr   = DERR_W'(err_s1) - DERR_W'(rd_st.prev_err);
		mag    = err_s1[ERR_W-1] ? ERR_W'(-err_s1) : ERR_W'(err_s1);
		dz_hit = mag < ERR_W'(cfg.dz);
		prod_p = PP_W'($signed({1'b0, cfg.kp})) * PP_W'(derr);
		prod_i = PI_W'($signed({1'b0, cfg.ki})) * PI_W'(err_s1);
		prod_l = PL_W'(rd_st.acc) * PL_W'($signed({1'b0, cfg.leak}));
	end

	always_ff @(posedge clk) begin
		if (en.ld2) begin
			ch_s2     <= ch_s1;
			rng_s2    <= rng_s1;
			dz_s2     <= dz_hit;
			leak_s2   <= dz_hit && tz_s1;
			err_s2    <= err_s1;
			acc_s2    <= rd_st.acc;
			prod_p_s2 <= prod_p;
			prod_i_s2 <= prod_i;
			prod_l_s2 <= prod_l;
		end
	end

	always_comb begin
		p_term   = SUM_W'(prod_p_s2 >>> PROD_SHIFT);
		i_term   = dz_s2 ? '0 : SUM_W'(prod_i_s2 >>> PROD_SHIFT);
		// leak divides toward zero: bias negative products before the shift
		leak_rnd = prod_l_s2 + (prod_l_s2[PL_W-1] ? LEAK_RND : '0);
		base     = leak_s2 ? SUM_W'(leak_rnd >>> LEAK_FRAC) : SUM_W'(acc_s2);
		sum      = base + p_term + i_term;
	end

	always_ff @(posedge clk) begin
		if (en.ld3) begin
			ch_s3  <= ch_s2;
			rng_s3 <= rng_s2;
			err_s3 <= err_s2;
			sum_s3 <= sum;
		end
	end

	always_comb begin
		lim_full = $signed(SUM_W'({cfg.lim, {ACC_FRAC{1'b0}}}));
		priority if (sum_s3 > lim_full) begin
			acc_new = lim_full;
		end else if (sum_s3 < -lim_full) begin
			acc_new = -lim_full;
		end else begin
			acc_new = sum_s3;
		end
		// limits are whole units, so truncate first and clamp the integer part
		rnd_up   = sum_s3[SUM_W-1] && (|sum_s3[ACC_FRAC-1:0]);
		hi_trunc = $signed(sum_s3[SUM_W-1:ACC_FRAC]) + $signed(HI_W'(rnd_up));
		lim_d    = $signed(HI_W'(cfg.lim));
		priority if (hi_trunc > lim_d) begin
			drv_sel = lim_d;
		end else if (hi_trunc < -lim_d) begin
			drv_sel = -lim_d;
		end else begin
			drv_sel = hi_trunc;
		end
	end

	assign res.ch          = ch_s3;
	assign res.rng         = rng_s3;
	assign res.st.acc      = ACC_W'(acc_new);
	assign res.st.prev_err = err_s3;
	assign res.drive       = rng_s3 ? DRV_W'(drv_sel) : '0;

	assign stage_ch = {ch_s3, ch_s2, ch_s1};

endmodule

[rtl/multi_channel_incremental_pi.sv]
`timescale 1ns / 1ps
// path: an accepted sample passes stages 1, 2 and 3, then the output register
// throughput: one sample per cycle unless drive_stall holds the output; a sample
// waits while its channel still sits in one of the three read-modify-write stages
// reset: gains, limits, dead zone and leak return to defaults, every channel reads
// as zero state at once through per-channel written flags, no clearing pass
module multi_channel_incremental_pi #(
	parameter int NUM_CHANNELS = 4
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write,
	input  logic [mcipi_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mcipi_pkg::CFG_W-1:0]     cfg_data,
	input  logic                            sample_valid,
	output logic                            sample_stall,
	input  mcipi_pkg::sample_t              sample,
	output logic                            drive_valid,
	input  logic                            drive_stall,
	output mcipi_pkg::drive_t               drive
);
	import mcipi_pkg::*;

	localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

	cfg_t        cfg_q;
	pipe_en_t    en;
	chan_state_t rd_st;
	result_t     res;
	drive_t      drive_s4;
	logic [2:0][CH_W-1:0] stage_ch;

	logic vld_s1, vld_s2, vld_s3, vld_s4;
	logic rdy1, rdy2, rdy3, rdy4;
	logic ld4;
	logic in_rng;
	logic hazard;
	logic accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.kp   <= KP_RESET;
			cfg_q.ki   <= KI_RESET;
			cfg_q.dz   <= DZ_RESET;
			cfg_q.lim  <= LIM_RESET;
			cfg_q.leak <= LEAK_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_KP:   cfg_q.kp   <= cfg_data;
				REG_KI:   cfg_q.ki   <= cfg_data;
				REG_DZ:   cfg_q.dz   <= cfg_data[DZ_W-1:0];
				REG_LIM:  cfg_q.lim  <= cfg_data[LIM_W-1:0];
				REG_LEAK: cfg_q.leak <= cfg_data[LEAK_W-1:0];
				default: ;
			endcase
		end
	end

	assign in_rng = 32'(sample.motor_index) < NUM_CHANNELS;

	// a channel still in flight has not written its state back yet
	assign hazard = in_rng && (
		(vld_s1 && stage_ch[0] == sample.motor_index) ||
		(vld_s2 && stage_ch[1] == sample.motor_index) ||
		(vld_s3 && stage_ch[2] == sample.motor_index));

	assign rdy4 = !vld_s4 || !drive_stall;
	assign rdy3 = !vld_s3 || rdy4;
	assign rdy2 = !vld_s2 || rdy3;
	assign rdy1 = !vld_s1 || rdy2;

	assign accept       = sample_valid && rdy1 && !hazard;
	assign sample_stall = !rdy1 || hazard;

	assign en.ld1 = accept;
	assign en.ld2 = vld_s1 && rdy2;
	assign en.ld3 = vld_s2 && rdy3;
	assign ld4    = vld_s3 && rdy4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (rdy1) begin
				vld_s1 <= accept;
			end
			if (rdy2) begin
				vld_s2 <= vld_s1;
			end
			if (rdy3) begin
				vld_s3 <= vld_s2;
			end
			if (rdy4) begin
				vld_s4 <= vld_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld4) begin
			drive_s4.channel   <= res.ch;
			drive_s4.pwm_drive <= res.drive;
		end
	end

	assign drive_valid = vld_s4;
	assign drive       = drive_s4;

	mcipi_state_mem #(
		.NUM_CHANNELS(NUM_CHANNELS),
		.AW(AW)
	) u_state_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept && in_rng),
		.rd_addr (AW'(sample.motor_index)),
		.rd_data (rd_st),
		.wr_en   (ld4 && res.rng),
		.wr_addr (AW'(res.ch)),
		.wr_data (res.st)
	);

	mcipi_datapath u_datapath (
		.clk      (clk),
		.en       (en),
		.smp      (sample),
		.smp_rng  (in_rng),
		.rd_st    (rd_st),
		.cfg      (cfg_q),
		.stage_ch (stage_ch),
		.res      (res)
	);

endmodule
